/* rtl/core/lfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU frame replacement package
// Request and response payload types and the command codes.
// ----------------------------------------------------------------------------
package lfr_pkg;

	localparam logic CMD_REFERENCE = 1'b0;
	localparam logic CMD_RELEASE   = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] process_id;
		logic [7:0] virtual_page;
	} lfr_req_t;

	typedef struct packed {
		logic       hit;
		logic [6:0] frame_index;
		logic       evicted;
		logic [7:0] evicted_owner;
		logic [7:0] evicted_page;
		logic [7:0] frames_released;
		logic [7:0] free_frames;
	} lfr_rsp_t;

endpackage

/* rtl/core/lfr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/lfu_frame_replacement.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU frame replacement
// Frame table under least-frequently-used replacement, held in one RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload     Moves
//  -------   ---------------------   ---------   ------------------------------
//  request   req_valid / req_stall   lfr_req_t   reference or release command
//  response  rsp_valid / rsp_stall   lfr_rsp_t   one result per request
//
// Every request runs through the controller states in order: a sweep
// reads each frame entry once (one RAM read per cycle), a drain state
// empties the read pipeline, a commit state commits the result and the
// idle state takes the next request.
// After reset a clearing pass zeroes the table; requests are stalled
// during it. A stalled response holds in the output register; the commit
// state waits only when that register is still occupied.
//
module lfu_frame_replacement #(
	parameter int FRAMES     = 128,
	parameter int COUNT_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  lfr_pkg::lfr_req_t req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output lfr_pkg::lfr_rsp_t rsp
);

	import lfr_pkg::*;

	// Address and count widths.
	localparam int AW = $clog2(FRAMES);
	localparam int CW = $clog2(FRAMES + 1);
	// Entry layout: {valid, owner, page, use count}.
	localparam int EW = 17 + COUNT_BITS;
	localparam logic [AW-1:0] LAST_ADDR = AW'(FRAMES - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Controller states.
	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_COMMIT = 3'd4;

	logic [2:0]    state_q;
	logic [AW-1:0] ptr_q;

	// The accepted request.
	logic       cmd_q;
	logic [7:0] pid_q;
	logic [7:0] vpg_q;

	// Read pipeline: entry data arrives in the cycle after its address.
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	logic [EW-1:0] rd_data;

	// Sweep results.
	logic                  found_q;
	logic [AW-1:0]         match_q;
	logic [COUNT_BITS-1:0] match_cnt_q;
	logic                  have_free_q;
	logic [AW-1:0]         free_idx_q;
	logic                  have_min_q;
	logic [COUNT_BITS-1:0] min_q;
	logic [AW-1:0]         victim_q;
	logic [7:0]            vic_own_q;
	logic [7:0]            vic_pg_q;
	logic [CW-1:0]         released_q;
	logic [CW-1:0]         free_total_q;

	// Response register.
	logic     rsp_valid_q;
	lfr_rsp_t rsp_q;
	lfr_rsp_t rsp_next;

	// RAM ports.
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;

	// Fields of the entry just read.
	logic                  ent_valid;
	logic [7:0]            ent_owner;
	logic [7:0]            ent_page;
	logic [COUNT_BITS-1:0] ent_count;
	logic                  owner_hit;
	logic                  release_hit;

	logic                  commit_go;
	logic [AW-1:0]         slot;
	logic [COUNT_BITS-1:0] slot_count;
	logic [CW-1:0]         free_next;
	logic [AW+6:0]         slot_ext;
	logic [CW+7:0]         released_ext;
	logic [CW+7:0]         free_ext;

	assign ent_valid = rd_data[EW-1];
	assign ent_owner = rd_data[EW-2 -: 8];
	assign ent_page  = rd_data[EW-10 -: 8];
	assign ent_count = rd_data[COUNT_BITS-1:0];

	assign owner_hit   = ent_valid && (ent_owner == pid_q);
	assign release_hit = rd_vld_s1 && (cmd_q == CMD_RELEASE) && owner_hit;

	// Requests enter only while the controller is idle.
	assign req_stall = (state_q != ST_IDLE);
	assign commit_go = (state_q == ST_COMMIT) && (!rsp_valid_q || !rsp_stall);

	lfr_ram #(
		.WIDTH (EW),
		.DEPTH (FRAMES)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (state_q == ST_SCAN),
		.rd_addr (ptr_q),
		.rd_data (rd_data)
	);

	// Choose the frame a reference lands in: the match on a hit, else the
	// lowest free frame, else the least-used victim.
	always_comb begin
		if (found_q) begin
			slot       = match_q;
			slot_count = (match_cnt_q == COUNT_MAX) ? match_cnt_q
			                                        : match_cnt_q + COUNT_BITS'(1);
		end else if (have_free_q) begin
			slot       = free_idx_q;
			slot_count = COUNT_BITS'(1);
		end else begin
			slot       = victim_q;
			slot_count = COUNT_BITS'(1);
		end

		if (cmd_q == CMD_RELEASE) begin
			free_next = free_total_q + released_q;
		end else if (!found_q && have_free_q) begin
			free_next = free_total_q - CW'(1);
		end else begin
			free_next = free_total_q;
		end

		slot_ext     = {7'd0, slot};
		released_ext = {8'd0, released_q};
		free_ext     = {8'd0, free_next};
	end

	// Response payload. Fields that carry no meaning for the request stay zero.
	always_comb begin
		rsp_next             = '0;
		rsp_next.free_frames = free_ext[7:0];
		if (cmd_q == CMD_RELEASE) begin
			rsp_next.frames_released = released_ext[7:0];
		end else begin
			rsp_next.hit         = found_q;
			rsp_next.frame_index = slot_ext[6:0];
			if (!found_q && !have_free_q) begin
				rsp_next.evicted       = 1'b1;
				rsp_next.evicted_owner = vic_own_q;
				rsp_next.evicted_page  = vic_pg_q;
			end
		end
	end

	// Write port: the clearing pass, releases during the sweep, and the
	// commit of a reference are confined to distinct states.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = '0;
		if (state_q == ST_CLEAR) begin
			wr_en = 1'b1;
		end else if (release_hit) begin
			// The sweep reads ahead of this address, so no collision.
			wr_en   = 1'b1;
			wr_addr = rd_idx_s1;
		end else if (commit_go && (cmd_q == CMD_REFERENCE)) begin
			wr_en   = 1'b1;
			wr_addr = slot;
			wr_data = {1'b1, pid_q, vpg_q, slot_count};
		end
	end

	// Controller.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			ptr_q        <= '0;
			rd_vld_s1    <= 1'b0;
			free_total_q <= CW'(FRAMES);
			rsp_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (commit_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (ptr_q == LAST_ADDR) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					ptr_q <= '0;
					if (req_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (ptr_q == LAST_ADDR) begin
						ptr_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (commit_go) begin
						free_total_q <= free_next;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture, sweep trackers and response payload.
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && req_valid) begin
			cmd_q       <= req.command;
			pid_q       <= req.process_id;
			vpg_q       <= req.virtual_page;
			found_q     <= 1'b0;
			have_free_q <= 1'b0;
			have_min_q  <= 1'b0;
			released_q  <= '0;
		end
		if (rd_vld_s1) begin
			if (ent_valid) begin
				if (!found_q && owner_hit && (ent_page == vpg_q)) begin
					found_q     <= 1'b1;
					match_q     <= rd_idx_s1;
					match_cnt_q <= ent_count;
				end
				if (!have_min_q || (ent_count < min_q)) begin
					have_min_q <= 1'b1;
					min_q      <= ent_count;
					victim_q   <= rd_idx_s1;
					vic_own_q  <= ent_owner;
					vic_pg_q   <= ent_page;
				end
			end else if (!have_free_q) begin
				have_free_q <= 1'b1;
				free_idx_q  <= rd_idx_s1;
			end
			if (release_hit) begin
				released_q <= released_q + CW'(1);
			end
		end
		rd_idx_s1 <= ptr_q;
		if (commit_go) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* rtl/core/lfr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU frame replacement checker
// Port-level properties of the frame table, bound to the top level.
// ----------------------------------------------------------------------------
module lfr_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input lfr_pkg::lfr_req_t req,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input lfr_pkg::lfr_rsp_t rsp
);

	import lfr_pkg::*;

	// A stalled response keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// An accepted request occupies the block for its sweep.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted during a sweep");

	// A hit neither evicts nor releases.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |-> !rsp.evicted && (rsp.frames_released == 8'd0))
		else $error("hit response carries eviction or release");

	// Eviction only happens with no free frame left.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.evicted |-> (rsp.free_frames == 8'd0))
		else $error("eviction while frames were free");

	// Without an eviction the victim fields read zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.evicted |->
			(rsp.evicted_owner == 8'd0) && (rsp.evicted_page == 8'd0))
		else $error("victim fields set without eviction");

endmodule

bind lfu_frame_replacement lfr_checker u_lfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

/* verif/tb_lfu_frame_replacement.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU frame replacement testbench
// A short directed table of requests runs first, followed by random traffic
// in four phases of sender idling and receiver stalls. Each response is
// compared field by field with its typed-in answer or with a behavioral
// frame table kept here that tracks ownership, pages, use counts, free count.
// ----------------------------------------------------------------------------
module tb_lfu_frame_replacement;

	import lfr_pkg::*;

	localparam int FRAMES     = 128;
	localparam int COUNT_BITS = 16;

	// Random requests per idling phase, four phases in all.
	localparam int PHASE_ITEMS = 225;
	localparam int PHASE_SEND_IDLE [4]  = '{0, 70, 0, 15};
	localparam int PHASE_RECV_STALL [4] = '{0, 0, 70, 15};

	// One row of the directed table. Rows with has_answer set carry a response
	// that can be read straight off the frame table. Those rows are compared
	// against the typed-in answer, and the evicted fields are zero there.
	// Other rows are checked against the frame table model.
	typedef struct packed {
		logic       command;
		logic [7:0] process_id;
		logic [7:0] virtual_page;
		logic       has_answer;
		logic       hit;
		logic [6:0] frame_index;
		logic [7:0] frames_released;
		logic [7:0] free_frames;
	} step_row_t;

	localparam int DIRECTED_COUNT = 22;
	localparam step_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		// The first reference after reset takes frame 0.
		'{CMD_REFERENCE, 8'h00, 8'h00, 1'b1, 1'b0, 7'd0, 8'd0, 8'd127},
		// A process that owns nothing frees nothing, and its page field is ignored.
		'{CMD_RELEASE,   8'hFF, 8'hA5, 1'b1, 1'b0, 7'd0, 8'd0, 8'd127},
		'{CMD_REFERENCE, 8'h00, 8'h00, 1'b1, 1'b1, 7'd0, 8'd0, 8'd127},
		'{CMD_REFERENCE, 8'hFF, 8'hFF, 1'b1, 1'b0, 7'd1, 8'd0, 8'd126},
		'{CMD_REFERENCE, 8'hFF, 8'h00, 1'b1, 1'b0, 7'd2, 8'd0, 8'd125},
		'{CMD_REFERENCE, 8'h00, 8'hFF, 1'b1, 1'b0, 7'd3, 8'd0, 8'd124},
		'{CMD_REFERENCE, 8'h00, 8'hFF, 1'b0, 1'b0, 7'd0, 8'd0, 8'd0},
		// Releasing process 0 frees frames 0 and 3 and leaves holes.
		'{CMD_RELEASE,   8'h00, 8'h00, 1'b1, 1'b0, 7'd0, 8'd2, 8'd126},
		// The lowest free frame is reused first.
		'{CMD_REFERENCE, 8'h55, 8'hAA, 1'b1, 1'b0, 7'd0, 8'd0, 8'd125},
		'{CMD_REFERENCE, 8'hAA, 8'h55, 1'b1, 1'b0, 7'd3, 8'd0, 8'd124},
		'{CMD_REFERENCE, 8'h80, 8'h01, 1'b0, 1'b0, 7'd0, 8'd0, 8'd0},
		'{CMD_REFERENCE, 8'h7F, 8'hFE, 1'b0, 1'b0, 7'd0, 8'd0, 8'd0},
		'{CMD_REFERENCE, 8'h7F, 8'hFE, 1'b0, 1'b0, 7'd0, 8'd0, 8'd0},
		'{CMD_REFERENCE, 8'h7F, 8'hFE, 1'b0, 1'b0, 7'd0, 8'd0, 8'd0},
		'{CMD_RELEASE,   8'hFF, 8'h00, 1'b1, 1'b0, 7'd0, 8'd2, 8'd124},
		'{CMD_RELEASE,   8'h55, 8'h00, 1'b0, 1'b0, 7'd0, 8'd0, 8'd0},
		'{CMD_RELEASE,   8'hAA, 8'h00, 1'b0, 1'b0, 7'd0, 8'd0, 8'd0},
		'{CMD_RELEASE,   8'h80, 8'h00, 1'b0, 1'b0, 7'd0, 8'd0, 8'd0},
		// After this release the table is empty again.
		'{CMD_RELEASE,   8'h7F, 8'h00, 1'b1, 1'b0, 7'd0, 8'd1, 8'd128},
		'{CMD_RELEASE,   8'h7F, 8'hFF, 1'b1, 1'b0, 7'd0, 8'd0, 8'd128},
		'{CMD_REFERENCE, 8'h01, 8'h80, 1'b1, 1'b0, 7'd0, 8'd0, 8'd127},
		'{CMD_RELEASE,   8'h01, 8'h80, 1'b1, 1'b0, 7'd0, 8'd1, 8'd128}
	};

	logic     clk;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	lfr_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	lfr_rsp_t rsp;

	// The answer typed in for the request now on the bus. It is driven
	// together with the payload, so it is sampled at the same edge.
	logic     answer_fixed = 1'b0;
	lfr_rsp_t answer_typed = '0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int errors         = 0;

	// Frame table model: a copy of the block's state.
	logic                  frame_used [FRAMES];
	logic [7:0]            owner_of   [FRAMES];
	logic [7:0]            page_of    [FRAMES];
	logic [COUNT_BITS-1:0] uses       [FRAMES];
	int                    free_count;

	// Responses still owed by the block, oldest first.
	lfr_rsp_t lfu_answers [$];

	lfu_frame_replacement #(
		.FRAMES     (FRAMES),
		.COUNT_BITS (COUNT_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Generous fixed limit. A correct run needs well under a tenth of this.
	initial begin
		#4000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Apply one request to the frame table model and return the response that
	// the block owes for it. A reference scans every frame once. During that
	// scan it looks for a matching owner and page, for the first free frame,
	// and for the valid frame with the smallest count, the lowest index
	// winning ties.
	function automatic lfr_rsp_t lfu_access(input lfr_req_t r);
		lfr_rsp_t              a;
		logic                  found;
		logic                  have_free;
		logic                  have_min;
		int                    i;
		int                    match;
		int                    first_free;
		int                    victim;
		int                    slot;
		int                    released;
		logic [COUNT_BITS-1:0] min_count;
		a          = '0;
		found      = 1'b0;
		have_free  = 1'b0;
		have_min   = 1'b0;
		match      = 0;
		first_free = 0;
		victim     = 0;
		released   = 0;
		min_count  = '0;
		if (r.command == CMD_RELEASE) begin
			for (i = 0; i < FRAMES; i++) begin
				if (frame_used[i] && owner_of[i] == r.process_id) begin
					frame_used[i] = 1'b0;
					uses[i]       = '0;
					released++;
					free_count++;
				end
			end
			a.frames_released = 8'(released);
		end else begin
			for (i = 0; i < FRAMES; i++) begin
				if (frame_used[i]) begin
					if (!found && owner_of[i] == r.process_id
							&& page_of[i] == r.virtual_page) begin
						found = 1'b1;
						match = i;
					end
					if (!have_min || uses[i] < min_count) begin
						have_min  = 1'b1;
						min_count = uses[i];
						victim    = i;
					end
				end else if (!have_free) begin
					have_free  = 1'b1;
					first_free = i;
				end
			end
			if (found) begin
				// A hit bumps the count, and the count saturates at all ones.
				a.hit         = 1'b1;
				a.frame_index = 7'(match);
				if (uses[match] != '1)
					uses[match] = uses[match] + 1'b1;
			end else begin
				if (have_free) begin
					slot = first_free;
					free_count--;
				end else begin
					slot            = victim;
					a.evicted       = 1'b1;
					a.evicted_owner = owner_of[slot];
					a.evicted_page  = page_of[slot];
				end
				frame_used[slot] = 1'b1;
				owner_of[slot]   = r.process_id;
				page_of[slot]    = r.virtual_page;
				uses[slot]       = COUNT_BITS'(1);
				a.frame_index    = 7'(slot);
			end
		end
		a.free_frames = 8'(free_count);
		return a;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endtask

	// Offer one request and hold it until the block takes it. A random idle
	// stretch may come first. During that stretch valid is low, so valid is
	// never lowered and raised within one time step.
	task automatic issue(input lfr_req_t r, input logic fixed, input lfr_rsp_t a);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		req_valid    <= 1'b1;
		req          <= r;
		answer_fixed <= fixed;
		answer_typed <= a;
		do @(posedge clk); while (req_stall);
	endtask

	// The receiver stalls at random, with a rate set per phase.
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Both channels are watched at the clock edge. An accepted request goes
	// through the frame table model at once, and its answer joins the queue.
	// Each accepted response is compared with the oldest answer in the queue.
	always @(posedge clk) begin
		lfr_rsp_t due;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				due = lfu_access(req);
				if (answer_fixed)
					due = answer_typed;
				lfu_answers = {lfu_answers, due};
			end
			if (rsp_valid && !rsp_stall) begin
				if (lfu_answers.size() == 0) begin
					$error("response with no request outstanding");
					errors++;
				end else begin
					due = lfu_answers.pop_front();
					check_field("hit", 8'(due.hit), 8'(rsp.hit));
					check_field("frame_index", 8'(due.frame_index), 8'(rsp.frame_index));
					check_field("evicted", 8'(due.evicted), 8'(rsp.evicted));
					check_field("evicted_owner", due.evicted_owner, rsp.evicted_owner);
					check_field("evicted_page", due.evicted_page, rsp.evicted_page);
					check_field("frames_released", due.frames_released,
						rsp.frames_released);
					check_field("free_frames", due.free_frames, rsp.free_frames);
				end
			end
		end
	end

	initial begin : stimulus
		lfr_req_t r;
		lfr_rsp_t a;
		int       i;
		int       n;
		int       p;
		int       roll;
		for (i = 0; i < FRAMES; i++) begin
			frame_used[i] = 1'b0;
			owner_of[i]   = '0;
			page_of[i]    = '0;
			uses[i]       = '0;
		end
		free_count = FRAMES;

		// Reset is held at the start and released at a clock edge. After that the
		// block runs its clearing pass and stalls requests until the pass is done.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < DIRECTED_COUNT; n++) begin
			r.command         = DIRECTED_ROWS[n].command;
			r.process_id      = DIRECTED_ROWS[n].process_id;
			r.virtual_page    = DIRECTED_ROWS[n].virtual_page;
			a                 = '0;
			a.hit             = DIRECTED_ROWS[n].hit;
			a.frame_index     = DIRECTED_ROWS[n].frame_index;
			a.frames_released = DIRECTED_ROWS[n].frames_released;
			a.free_frames     = DIRECTED_ROWS[n].free_frames;
			issue(r, DIRECTED_ROWS[n].has_answer, a);
		end
		// The sender pauses here until every response owed so far has come.
		req_valid <= 1'b0;
		do @(posedge clk); while (lfu_answers.size() != 0);

		// Most random traffic comes from a small working set of processes and
		// pages. Some pages are hot and collect counts, so the table fills,
		// hits repeat and the cold frames get evicted. The rest are releases of
		// working-set processes and noise over the full field ranges: stray
		// references and releases of processes that may own nothing.
		for (p = 0; p < 4; p++) begin
			send_idle_pct  = PHASE_SEND_IDLE[p];
			recv_stall_pct = PHASE_RECV_STALL[p];
			for (n = 0; n < PHASE_ITEMS; n++) begin
				roll           = $urandom_range(0, 99);
				r.virtual_page = 8'($urandom_range(0, 255));
				if (roll < 2) begin
					r.command    = CMD_RELEASE;
					r.process_id = 8'($urandom_range(0, 7));
				end else if (roll < 4) begin
					r.command    = CMD_RELEASE;
					r.process_id = 8'($urandom_range(0, 255));
				end else if (roll < 16) begin
					r.command    = CMD_REFERENCE;
					r.process_id = 8'($urandom_range(0, 255));
				end else begin
					r.command    = CMD_REFERENCE;
					r.process_id = 8'($urandom_range(0, 7));
					if ($urandom_range(0, 1) == 1)
						r.virtual_page = 8'($urandom_range(0, 3));
					else
						r.virtual_page = 8'($urandom_range(0, 31));
				end
				issue(r, 1'b0, '0);
			end
			req_valid <= 1'b0;
			do @(posedge clk); while (lfu_answers.size() != 0);
		end

		// Wait for any stray response to show up before the verdict.
		repeat (4 * FRAMES) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* files.f */
rtl/core/lfr_pkg.sv
rtl/core/lfr_ram.sv
rtl/core/lfu_frame_replacement.sv
rtl/core/lfr_checker.sv
verif/tb_lfu_frame_replacement.sv
